// ----- rtl/gate_stream_peephole_merge_cancel_assert.svh -----
// assertion macros for the gate stream peephole merge and cancel block
`ifndef GATE_STREAM_PEEPHOLE_MERGE_CANCEL_ASSERT_SVH
`define GATE_STREAM_PEEPHOLE_MERGE_CANCEL_ASSERT_SVH

// clocked check, switched off while reset is applied
`define GSPMC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define GSPMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gspmc_pkg.sv -----
// shared types and constants for the gate stream peephole merge and cancel block
`default_nettype none

package gspmc_pkg;

    localparam int unsigned QUBIT_BITS = 10;
    localparam int unsigned ANGLE_BITS = 32;
    localparam int unsigned KIND_BITS  = 4;

    localparam logic [KIND_BITS-1:0] KIND_I    = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_X    = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_Y    = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_Z    = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_H    = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_RX   = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_RY   = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_RZ   = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_CNOT = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_CZ   = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_SWAP = 4'd10;

    typedef struct packed {
        logic [KIND_BITS-1:0]  gate_kind;
        logic [QUBIT_BITS-1:0] first_qubit;
        logic [QUBIT_BITS-1:0] second_qubit;
        logic                  parameterized;
        logic [ANGLE_BITS-1:0] angle;
        logic                  end_of_circuit;
    } gate_in_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  out_kind;
        logic [QUBIT_BITS-1:0] out_first_qubit;
        logic [QUBIT_BITS-1:0] out_second_qubit;
        logic                  out_parameterized;
        logic [ANGLE_BITS-1:0] out_angle;
        logic                  gate_present;
        logic                  out_last;
    } gate_out_t;

endpackage

`default_nettype wire

// ----- rtl/gate_stream_peephole_merge_cancel.sv -----
// top level of the gate stream peephole merge and cancel block
`default_nettype none

// gate stream peephole merge and cancel
//
// gate / gate_valid / gate_ready carry one gate request per accepted cycle.
// result / result_valid / result_ready carry the emitted gates, in order.
// one gate is held back so that a following rotation of the same kind on the
// same first qubit can be merged into it, or a following equal X, Y, Z or H
// gate can cancel it; identity gates are dropped and flush the held gate
// each request yields zero, one or two results, decided in the accept cycle
// and written into a three entry result queue; the queue is registered and
// the output shows its head entry, so results leave in order
// a request is taken whenever the queue holds at most one result, so the block
// runs at one request per cycle while results are taken at that rate; a request
// that yields two results takes an extra queue entry
// the end of circuit request flushes the held gate, or produces an empty end
// marker when nothing is left, and the final result carries out_last
// reset empties the queue and drops the held gate; a stalled receiver fills the
// queue and gate_ready falls until results are taken again

module gate_stream_peephole_merge_cancel (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire gspmc_pkg::gate_in_t   gate,
    input  wire                        gate_valid,
    output logic                       gate_ready,
    output gspmc_pkg::gate_out_t       result,
    output logic                       result_valid,
    input  wire                        result_ready
);

    localparam int unsigned QUEUE_DEPTH = 3;

    // held gate
    logic                                held_valid_reg;
    logic                                held_valid_next;
    logic [gspmc_pkg::KIND_BITS-1:0]     held_kind_reg;
    logic [gspmc_pkg::KIND_BITS-1:0]     held_kind_next;
    logic [gspmc_pkg::QUBIT_BITS-1:0]    held_first_qubit_reg;
    logic [gspmc_pkg::QUBIT_BITS-1:0]    held_first_qubit_next;
    logic [gspmc_pkg::QUBIT_BITS-1:0]    held_second_qubit_reg;
    logic [gspmc_pkg::QUBIT_BITS-1:0]    held_second_qubit_next;
    logic                                held_parameterized_reg;
    logic                                held_parameterized_next;
    logic [gspmc_pkg::ANGLE_BITS-1:0]    held_angle_reg;
    logic [gspmc_pkg::ANGLE_BITS-1:0]    held_angle_next;

    // result queue, head at entry 0
    gspmc_pkg::gate_out_t queue_reg  [QUEUE_DEPTH];
    gspmc_pkg::gate_out_t queue_next [QUEUE_DEPTH];
    gspmc_pkg::gate_out_t shifted    [QUEUE_DEPTH];
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    // decode of the incoming request
    logic                              accept;
    logic                              pop;
    logic [gspmc_pkg::ANGLE_BITS-1:0]  in_angle;
    logic                              is_rot;
    logic                              is_inv;
    logic                              same;
    logic                              emit_held;
    logic                              emit_in;
    logic                              emit_flush;
    gspmc_pkg::gate_out_t              rec_held;
    gspmc_pkg::gate_out_t              rec_in;
    gspmc_pkg::gate_out_t              rec_flush;
    gspmc_pkg::gate_out_t              rec_marker;
    gspmc_pkg::gate_out_t              rec_a;
    gspmc_pkg::gate_out_t              rec_b;
    logic [1:0]                        push_count;
    logic [1:0]                        write_base;

    assign accept       = gate_valid && gate_ready;
    assign pop          = result_valid && result_ready;
    assign gate_ready   = (count_reg <= 2'd1);
    assign result_valid = (count_reg != 2'd0);
    assign result       = queue_reg[0];

    assign in_angle = gate.parameterized ? gate.angle : '0;
    assign is_rot   = gate.parameterized
                      && (gate.gate_kind >= gspmc_pkg::KIND_RX)
                      && (gate.gate_kind <= gspmc_pkg::KIND_RZ);
    assign is_inv   = !gate.parameterized
                      && (gate.gate_kind >= gspmc_pkg::KIND_X)
                      && (gate.gate_kind <= gspmc_pkg::KIND_H);
    assign same     = held_valid_reg
                      && (held_kind_reg == gate.gate_kind)
                      && (held_first_qubit_reg == gate.first_qubit);

    // held gate update and the gates emitted in the main step
    always_comb
    begin
        held_valid_next         = held_valid_reg;
        held_kind_next          = held_kind_reg;
        held_first_qubit_next   = held_first_qubit_reg;
        held_second_qubit_next  = held_second_qubit_reg;
        held_parameterized_next = held_parameterized_reg;
        held_angle_next         = held_angle_reg;
        emit_held               = 1'b0;
        emit_in                 = 1'b0;
        emit_flush              = 1'b0;
        if (accept)
        begin
            if (gate.gate_kind == gspmc_pkg::KIND_I)
            begin
                // identity: dropped, flushes the held gate
                emit_held       = held_valid_reg;
                held_valid_next = 1'b0;
            end
            else if (same && is_rot && held_parameterized_reg)
            begin
                // merge rotation, angle wraps modulo one turn
                held_angle_next        = held_angle_reg + in_angle;
                held_second_qubit_next = gate.second_qubit;
            end
            else if (same && is_inv && !held_parameterized_reg)
            begin
                // equal self inverse pair cancels
                held_valid_next = 1'b0;
            end
            else
            begin
                emit_held = held_valid_reg;
                if (is_rot || is_inv)
                begin
                    held_valid_next         = 1'b1;
                    held_kind_next          = gate.gate_kind;
                    held_first_qubit_next   = gate.first_qubit;
                    held_second_qubit_next  = gate.second_qubit;
                    held_parameterized_next = gate.parameterized;
                    held_angle_next         = in_angle;
                end
                else
                begin
                    held_valid_next = 1'b0;
                    emit_in         = 1'b1;
                end
            end
            // end of circuit flushes whatever is still held
            if (gate.end_of_circuit && held_valid_next)
            begin
                emit_flush      = 1'b1;
                held_valid_next = 1'b0;
            end
        end
    end

    // candidate result records
    always_comb
    begin
        rec_held.out_kind          = held_kind_reg;
        rec_held.out_first_qubit   = held_first_qubit_reg;
        rec_held.out_second_qubit  = held_second_qubit_reg;
        rec_held.out_parameterized = held_parameterized_reg;
        rec_held.out_angle         = held_parameterized_reg ? held_angle_reg : '0;
        rec_held.gate_present      = 1'b1;
        rec_held.out_last          = 1'b0;

        rec_in.out_kind            = gate.gate_kind;
        rec_in.out_first_qubit     = gate.first_qubit;
        rec_in.out_second_qubit    = gate.second_qubit;
        rec_in.out_parameterized   = gate.parameterized;
        rec_in.out_angle           = in_angle;
        rec_in.gate_present        = 1'b1;
        rec_in.out_last            = 1'b0;

        // flush uses the held gate as it stands after this request
        rec_flush.out_kind          = held_kind_next;
        rec_flush.out_first_qubit   = held_first_qubit_next;
        rec_flush.out_second_qubit  = held_second_qubit_next;
        rec_flush.out_parameterized = held_parameterized_next;
        rec_flush.out_angle         = held_parameterized_next ? held_angle_next : '0;
        rec_flush.gate_present      = 1'b1;
        rec_flush.out_last          = 1'b0;

        rec_marker                  = '0;
        rec_marker.out_kind         = gspmc_pkg::KIND_I;
    end

    // order the emitted records into at most two slots
    always_comb
    begin
        if (emit_held)
        begin
            rec_a = rec_held;
        end
        else if (emit_in)
        begin
            rec_a = rec_in;
        end
        else if (emit_flush)
        begin
            rec_a = rec_flush;
        end
        else
        begin
            rec_a = rec_marker;
        end

        if (emit_held && emit_in)
        begin
            rec_b = rec_in;
        end
        else
        begin
            rec_b = rec_flush;
        end

        push_count = {1'b0, emit_held} + {1'b0, emit_in} + {1'b0, emit_flush};
        if (accept && gate.end_of_circuit && (push_count == 2'd0))
        begin
            push_count = 2'd1;
        end

        // final result of the circuit
        if (gate.end_of_circuit)
        begin
            if (push_count == 2'd2)
            begin
                rec_b.out_last = 1'b1;
            end
            else
            begin
                rec_a.out_last = 1'b1;
            end
        end
    end

    // queue update: shift on pop, append behind what remains
    always_comb
    begin
        write_base = count_reg - {1'b0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
            begin
                shifted[i] = queue_reg[i + 1];
            end
            else
            begin
                shifted[i] = queue_reg[i];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            queue_next[i] = shifted[i];
            if ((push_count != 2'd0) && (2'(i) == write_base))
            begin
                queue_next[i] = rec_a;
            end
            if ((push_count == 2'd2) && (2'(i) == write_base + 2'd1))
            begin
                queue_next[i] = rec_b;
            end
        end
        count_next = write_base + (accept ? push_count : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_kind_reg          <= held_kind_next;
        held_first_qubit_reg   <= held_first_qubit_next;
        held_second_qubit_reg  <= held_second_qubit_next;
        held_parameterized_reg <= held_parameterized_next;
        held_angle_reg         <= held_angle_next;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

    // checks
`include "gate_stream_peephole_merge_cancel_assert.svh"

    `GSPMC_ASSERT_CLK(a_end_gives_result,
        (accept && gate.end_of_circuit) |=> result_valid,
        "end of circuit request produced no result")
    `GSPMC_ASSERT_CLK(a_end_clears_held,
        (accept && gate.end_of_circuit) |=> !held_valid_reg,
        "gate still held after end of circuit")
    `GSPMC_ASSERT_CLK(a_marker_is_last,
        (result_valid && !result.gate_present) |-> (result.out_last
            && (result.out_kind == gspmc_pkg::KIND_I) && !result.out_parameterized),
        "empty end marker malformed")

endmodule

`default_nettype wire
